>>> src/bilinear_image_resize_defines.svh
// Assertion macros for the bilinear resize block.
`ifndef BILINEAR_IMAGE_RESIZE_DEFINES_SVH
`define BILINEAR_IMAGE_RESIZE_DEFINES_SVH
`ifndef SYNTHESIS
// Checked on every rising edge outside reset.
`define BIR_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("bir: assertion failed");
// Antecedent in one cycle, consequent in the next.
`define BIR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bir: assertion failed");
`else
`define BIR_ASSERT(label, prop)
`define BIR_ASSERT_NEXT(label, ante, cons)
`endif
`endif

>>> src/bir_pkg.sv
// Shared types and constants of the bilinear resize block.
`timescale 1ns / 1ps
package bir_pkg;

    localparam int PIX_W     = 16;
    localparam int COORD_W   = 12;
    localparam int PLANE_W   = 2;
    localparam int CMD_W     = 1;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 24;
    localparam int SRC_DIM_W = 9;
    localparam int CH_W      = 2;
    localparam int DST_DIM_W = 13;
    localparam int SCALE_W   = 24;

    // Shared multiply-add operand widths.
    localparam int MAC_A_W = 25;
    localparam int MAC_B_W = 17;
    localparam int MAC_W   = 43;

    localparam logic [CMD_W-1:0] CMD_WRITE   = 1'b0;
    localparam logic [CMD_W-1:0] CMD_COMPUTE = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DST_WIDTH     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DST_HEIGHT    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_X_SCALE       = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_SCALE       = 3'd6;

    typedef struct packed {
        logic signed [MAC_A_W-1:0] a;
        logic signed [MAC_B_W-1:0] b;
        logic signed [MAC_W-1:0]   addend;
    } mac_op_t;

endpackage

>>> src/bir_req_if.sv
// Request channel: pixel writes and output pixel requests.
`timescale 1ns / 1ps
interface bir_req_if import bir_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [CMD_W-1:0]   cmd;
    logic [COORD_W-1:0] column;
    logic [COORD_W-1:0] row;
    logic [PLANE_W-1:0] plane;
    logic [PIX_W-1:0]   pixel_in;

    modport source (output valid, cmd, column, row, plane, pixel_in, input ready);
    modport sink (input valid, cmd, column, row, plane, pixel_in, output ready);
endinterface

>>> src/bir_res_if.sv
// Result channel: interpolated pixels.
`timescale 1ns / 1ps
interface bir_res_if import bir_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel_out;
    logic             out_of_range;

    modport source (output valid, pixel_out, out_of_range, input ready);
    modport sink (input valid, pixel_out, out_of_range, output ready);
endinterface

>>> src/bir_mac.sv
// Shared signed multiply-add unit with registered result.
`timescale 1ns / 1ps
module bir_mac import bir_pkg::*;
(
    input  logic                    clk,
    input  mac_op_t                 op,
    output logic signed [MAC_W-1:0] res
);

    logic signed [MAC_A_W+MAC_B_W-1:0] prod;
    logic signed [MAC_W-1:0]           res_reg;

    assign prod = op.a * op.b;

    always_ff @(posedge clk)
    begin
        res_reg <= op.addend + MAC_W'(prod);
    end

    assign res = res_reg;

endmodule

>>> src/bilinear_image_resize.sv
// Bilinear resize engine: source store, sequencer and output register.
//
//  channel   | dir | handshake          | payload
//  ----------+-----+--------------------+-------------------------------------
//  req       | in  | valid / ready      | cmd, column, row, plane, pixel_in
//  res       | out | valid / ready      | pixel_out, out_of_range
//  cfg       | in  | cfg_we, no wait    | cfg_index, cfg_wdata
//
// A pixel write is taken in S_IDLE. In an in-range compute, two coordinate
// multiplies and three blends share one multiplier, and the four neighbors
// come through the single read port of the source store. An out-of-range
// compute goes straight to S_OUT. A stalled result holds the sequencer in its
// last state; a new request is still taken while a result waits in the output
// register. Reset restores the register defaults; the source store is not cleared.
`timescale 1ns / 1ps
`include "bilinear_image_resize_defines.svh"
module bilinear_image_resize import bir_pkg::*;
#(
    parameter int MAX_SRC_WIDTH  = 256,
    parameter int MAX_SRC_HEIGHT = 256,
    parameter int MAX_PLANES     = 3
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    bir_req_if.sink               req,
    bir_res_if.source             res
);

    localparam int XW           = $clog2(MAX_SRC_WIDTH);
    localparam int YW           = $clog2(MAX_SRC_HEIGHT);
    localparam int PW           = (MAX_PLANES > 1) ? $clog2(MAX_PLANES) : 1;
    localparam int PLANE_STRIDE = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
    localparam int DEPTH        = MAX_PLANES * PLANE_STRIDE;
    localparam int AW           = $clog2(DEPTH);

    localparam logic [DST_DIM_W-1:0] MAX_W_D = DST_DIM_W'(MAX_SRC_WIDTH);
    localparam logic [DST_DIM_W-1:0] MAX_H_D = DST_DIM_W'(MAX_SRC_HEIGHT);
    localparam logic [2:0]           MAX_P_D = 3'(MAX_PLANES);

    typedef enum logic [11:0] {
        S_IDLE = 12'h001,
        S_MULX = 12'h002,
        S_MULY = 12'h004,
        S_IDX  = 12'h008,
        S_RDA  = 12'h010,
        S_RDB  = 12'h020,
        S_RDC  = 12'h040,
        S_RDD  = 12'h080,
        S_BLH1 = 12'h100,
        S_BLV  = 12'h200,
        S_FIN  = 12'h400,
        S_OUT  = 12'h800
    } state_t;

    function automatic logic [AW-1:0] mem_addr(
        input logic [PW-1:0] p,
        input logic [YW-1:0] r,
        input logic [XW-1:0] c
    );
        logic [AW-1:0] base;
        base = AW'(p) * AW'(PLANE_STRIDE);
        return base + AW'(r) * AW'(MAX_SRC_WIDTH) + AW'(c);
    endfunction

    // Configuration registers.
    logic [SRC_DIM_W-1:0] src_width_reg, src_height_reg;
    logic [CH_W-1:0]      channel_count_reg;
    logic [DST_DIM_W-1:0] dst_width_reg, dst_height_reg;
    logic [SCALE_W-1:0]   x_scale_reg, y_scale_reg;

    logic [DST_DIM_W-1:0] eff_sw, eff_sh, x_last, y_last;
    logic [2:0]           eff_ch;

    state_t state_reg, state_next;

    logic [COORD_W-1:0] col_reg, row_reg;
    logic [PW-1:0]      pl_reg;
    logic               oor_reg;
    logic [PIX_W-1:0]   val_reg;
    logic [XW-1:0]      i0_reg, i1_reg;
    logic [YW-1:0]      r0_reg, r1_reg;
    logic [PIX_W-1:0]   fx_reg, fy_reg;
    logic [PIX_W-1:0]   p00_reg, p10_reg, h0_reg;

    logic               out_valid_reg;
    logic [PIX_W-1:0]   out_pix_reg;
    logic               out_oor_reg;

    logic [PIX_W-1:0]   mem [DEPTH];
    logic [PIX_W-1:0]   mem_rdata_reg;
    logic [AW-1:0]      rd_addr, wr_addr;
    logic               mem_we;

    logic               req_fire, req_oor, out_free;
    logic [19:0]        ix, iy;
    logic               x_edge, y_edge;
    logic [DST_DIM_W-1:0] i0_next, i1_next, r0_next, r1_next;

    mac_op_t                 mac_op;
    logic signed [MAC_W-1:0] mac_res;
    logic [PIX_W-1:0]        blend_p0, blend_p1, blend_f;

    // Source size and channel count values outside their range act as the nearest legal value.
    always_comb
    begin
        if (src_width_reg == '0)
            eff_sw = DST_DIM_W'(1);
        else if (DST_DIM_W'(src_width_reg) > MAX_W_D)
            eff_sw = MAX_W_D;
        else
            eff_sw = DST_DIM_W'(src_width_reg);

        if (src_height_reg == '0)
            eff_sh = DST_DIM_W'(1);
        else if (DST_DIM_W'(src_height_reg) > MAX_H_D)
            eff_sh = MAX_H_D;
        else
            eff_sh = DST_DIM_W'(src_height_reg);

        if (channel_count_reg == '0)
            eff_ch = 3'd1;
        else if (3'(channel_count_reg) > MAX_P_D)
            eff_ch = MAX_P_D;
        else
            eff_ch = 3'(channel_count_reg);
    end

    assign x_last = eff_sw - DST_DIM_W'(1);
    assign y_last = eff_sh - DST_DIM_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_width_reg     <= SRC_DIM_W'(1);
            src_height_reg    <= SRC_DIM_W'(1);
            channel_count_reg <= CH_W'(3);
            dst_width_reg     <= DST_DIM_W'(1);
            dst_height_reg    <= DST_DIM_W'(1);
            x_scale_reg       <= '0;
            y_scale_reg       <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SRC_WIDTH:     src_width_reg     <= cfg_wdata[SRC_DIM_W-1:0];
                CFG_SRC_HEIGHT:    src_height_reg    <= cfg_wdata[SRC_DIM_W-1:0];
                CFG_CHANNEL_COUNT: channel_count_reg <= cfg_wdata[CH_W-1:0];
                CFG_DST_WIDTH:     dst_width_reg     <= cfg_wdata[DST_DIM_W-1:0];
                CFG_DST_HEIGHT:    dst_height_reg    <= cfg_wdata[DST_DIM_W-1:0];
                CFG_X_SCALE:       x_scale_reg       <= cfg_wdata[SCALE_W-1:0];
                CFG_Y_SCALE:       y_scale_reg       <= cfg_wdata[SCALE_W-1:0];
                default:           ;
            endcase
        end
    end

    // Request side.
    assign req.ready = (state_reg == S_IDLE);
    assign req_fire  = req.valid && req.ready;
    assign req_oor   = ({1'b0, req.column} >= dst_width_reg)
                    || ({1'b0, req.row} >= dst_height_reg)
                    || ({1'b0, req.plane} >= eff_ch);

    assign mem_we = req_fire && (req.cmd == CMD_WRITE)
                 && ({1'b0, req.column} < eff_sw)
                 && ({1'b0, req.row} < eff_sh)
                 && ({1'b0, req.plane} < eff_ch);
    assign wr_addr = mem_addr(req.plane[PW-1:0], req.row[YW-1:0], req.column[XW-1:0]);

    assign out_free = !out_valid_reg || res.ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
                if (req_fire && req.cmd == CMD_COMPUTE)
                    state_next = req_oor ? S_OUT : S_MULX;
            S_MULX: state_next = S_MULY;
            S_MULY: state_next = S_IDX;
            S_IDX:  state_next = S_RDA;
            S_RDA:  state_next = S_RDB;
            S_RDB:  state_next = S_RDC;
            S_RDC:  state_next = S_RDD;
            S_RDD:  state_next = S_BLH1;
            S_BLH1: state_next = S_BLV;
            S_BLV:  state_next = S_FIN;
            S_FIN:  state_next = S_OUT;
            S_OUT:
                if (out_free)
                    state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // Neighbor indices; an edge column or row takes the last source index twice,
    // which makes the blend return that sample unchanged.
    assign ix     = mac_res[35:16];
    assign iy     = mac_res[35:16];
    assign x_edge = ({1'b0, col_reg} == dst_width_reg - DST_DIM_W'(1))
                 || (eff_sw == DST_DIM_W'(1));
    assign y_edge = ({1'b0, row_reg} == dst_height_reg - DST_DIM_W'(1))
                 || (eff_sh == DST_DIM_W'(1));

    always_comb
    begin
        i0_next = (x_edge || ix > 20'(x_last)) ? x_last : ix[DST_DIM_W-1:0];
        i1_next = (x_edge || ix >= 20'(x_last)) ? x_last
                                                : ix[DST_DIM_W-1:0] + DST_DIM_W'(1);
        r0_next = (y_edge || iy > 20'(y_last)) ? y_last : iy[DST_DIM_W-1:0];
        r1_next = (y_edge || iy >= 20'(y_last)) ? y_last
                                                : iy[DST_DIM_W-1:0] + DST_DIM_W'(1);
    end

    // Operand select for the shared multiply-add.
    always_comb
    begin
        blend_p0 = '0;
        blend_p1 = '0;
        blend_f  = '0;
        case (state_reg)
            S_RDC:
            begin
                blend_p0 = p00_reg;
                blend_p1 = mem_rdata_reg;
                blend_f  = fx_reg;
            end
            S_BLH1:
            begin
                blend_p0 = p10_reg;
                blend_p1 = mem_rdata_reg;
                blend_f  = fx_reg;
            end
            S_BLV:
            begin
                blend_p0 = h0_reg;
                blend_p1 = mac_res[31:16];
                blend_f  = fy_reg;
            end
            default: ;
        endcase

        // blend = (p0 * 2^16 + f * (p1 - p0)) >> 16
        mac_op.a      = MAC_A_W'($signed({1'b0, blend_p1}) - $signed({1'b0, blend_p0}));
        mac_op.b      = $signed({1'b0, blend_f});
        mac_op.addend = $signed({{(MAC_W-32){1'b0}}, blend_p0, 16'h0000});
        case (state_reg)
            S_MULX:
            begin
                mac_op.a      = $signed({1'b0, x_scale_reg});
                mac_op.b      = $signed({5'b0, col_reg});
                mac_op.addend = '0;
            end
            S_MULY:
            begin
                mac_op.a      = $signed({1'b0, y_scale_reg});
                mac_op.b      = $signed({5'b0, row_reg});
                mac_op.addend = '0;
            end
            default: ;
        endcase
    end

    bir_mac u_mac (
        .clk (clk),
        .op  (mac_op),
        .res (mac_res)
    );

    always_comb
    begin
        case (state_reg)
            S_RDB:   rd_addr = mem_addr(pl_reg, r0_reg, i1_reg);
            S_RDC:   rd_addr = mem_addr(pl_reg, r1_reg, i0_reg);
            S_RDD:   rd_addr = mem_addr(pl_reg, r1_reg, i1_reg);
            default: rd_addr = mem_addr(pl_reg, r0_reg, i0_reg);
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[wr_addr] <= req.pixel_in;
        mem_rdata_reg <= mem[rd_addr];
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
                if (req_fire && req.cmd == CMD_COMPUTE)
                begin
                    col_reg <= req.column;
                    row_reg <= req.row;
                    pl_reg  <= req.plane[PW-1:0];
                    oor_reg <= req_oor;
                    val_reg <= '0;
                end
            S_MULY:
            begin
                i0_reg <= i0_next[XW-1:0];
                i1_reg <= i1_next[XW-1:0];
                fx_reg <= mac_res[15:0];
            end
            S_IDX:
            begin
                r0_reg <= r0_next[YW-1:0];
                r1_reg <= r1_next[YW-1:0];
                fy_reg <= mac_res[15:0];
            end
            S_RDB:
                p00_reg <= mem_rdata_reg;
            S_RDD:
            begin
                p10_reg <= mem_rdata_reg;
                h0_reg  <= mac_res[31:16];
            end
            S_FIN:
                val_reg <= mac_res[31:16];
            default: ;
        endcase
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (state_reg == S_OUT && out_free)
            out_valid_reg <= 1'b1;
        else if (res.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_OUT && out_free)
        begin
            out_pix_reg <= val_reg;
            out_oor_reg <= oor_reg;
        end
    end

    assign res.valid        = out_valid_reg;
    assign res.pixel_out    = out_pix_reg;
    assign res.out_of_range = out_oor_reg;

    `BIR_ASSERT(a_write_only_idle, mem_we |-> state_reg == S_IDLE)
    `BIR_ASSERT(a_col_order, state_reg == S_RDA |-> (i0_reg <= i1_reg) && (DST_DIM_W'(i1_reg) < eff_sw))
    `BIR_ASSERT(a_row_order, state_reg == S_RDA |-> (r0_reg <= r1_reg) && (DST_DIM_W'(r1_reg) < eff_sh))
    `BIR_ASSERT(a_oor_zero, out_valid_reg && out_oor_reg |-> out_pix_reg == '0)
    `BIR_ASSERT_NEXT(a_result_loaded, state_reg == S_OUT && out_free, out_valid_reg && state_reg == S_IDLE)

endmodule
